/* rtl/rcop_pkg.sv */
// Shared types, constants and operation codes of the compacting object pool.
package rcop_pkg;

   localparam int MaxObjects = 32;
   localparam int BankBytes  = 4096;
   localparam int IdBits     = 16;

   localparam logic [1:0] OP_INSERT   = 2'd0;
   localparam logic [1:0] OP_RETRIEVE = 2'd1;
   localparam logic [1:0] OP_ADD      = 2'd2;
   localparam logic [1:0] OP_DROP     = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [12:0] request_bytes;
      logic [15:0] handle;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] result_handle;
      logic        found;
      logic        bank;
      logic [11:0] offset;
      logic [11:0] old_offset;
      logic [12:0] length;
      logic        last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;      // capture the request
      logic search_clr; // restart the table walk
      logic search_step;
      logic flip;       // start of compaction
      logic move_step;  // examine one entry while packing
      logic pack_end;   // finish compaction
      logic do_insert;
      logic do_update;  // apply add or drop on the found entry
      logic emit_ans;
      logic emit_fail;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic bad_size;
      logic need_compact;
      logic can_insert;
      logic search_done;
      logic hit;
      logic move_done;
   } sts_type;

endpackage

/* rtl/refcount_compacting_object_pool.sv */
// Top level of the reference-counted compacting object pool.
// A request is taken when start is high and busy low. Retrieve, add and drop
// walk the object table one entry per cycle until the handle is found or the
// table ends. Insert answers a failure straight from its size check when the
// requested size is out of range. When a compaction is needed the pool first
// runs the compaction walk, emitting one move descriptor per live entry before
// the answer. Each result is shown for one cycle under rsp_strobe and must be taken
// then; the receiver cannot stall the pool.
module refcount_compacting_object_pool #(
   parameter int MAX_OBJECTS = rcop_pkg::MaxObjects,
   parameter int BANK_BYTES  = rcop_pkg::BankBytes,
   parameter int ID_BITS     = rcop_pkg::IdBits
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rcop_pkg::req_type req_data,
   output logic              rsp_strobe,
   output rcop_pkg::rsp_type rsp_data
);

   rcop_pkg::cmd_type cmd;
   rcop_pkg::sts_type sts;

   // Sequencer.
   rcop_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .op(req_data.op),
      .sts(sts), .cmd(cmd), .busy(busy)
   );

   // Table and result path.
   rcop_datapath #(
      .MAX_OBJECTS(MAX_OBJECTS), .BANK_BYTES(BANK_BYTES), .ID_BITS(ID_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd), .sts(sts),
      .rsp(rsp_data), .rsp_strobe(rsp_strobe)
   );

endmodule

/* rtl/rcop_ctrl.sv */
// Controller state machine of the compacting object pool.
module rcop_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        op,
   input  rcop_pkg::sts_type sts,
   output rcop_pkg::cmd_type cmd,
   output logic              busy
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_PACK   = 3'd2;
   localparam logic [2:0] ST_INSERT = 3'd3;
   localparam logic [2:0] ST_SEARCH = 3'd4;

   logic [2:0] state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch      = 1'b1;
               cmd.search_clr = 1'b1;
               state_in = (op == rcop_pkg::OP_INSERT) ? ST_DECIDE : ST_SEARCH;
            end
         end
         ST_DECIDE: begin
            if (sts.bad_size) begin
               cmd.emit_fail = 1'b1;
               state_in = ST_IDLE;
            end else if (sts.need_compact) begin
               cmd.flip = 1'b1;
               state_in = ST_PACK;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_PACK: begin
            if (sts.move_done) begin
               cmd.pack_end = 1'b1;
               state_in = ST_INSERT;
            end else begin
               cmd.move_step = 1'b1;
            end
         end
         ST_INSERT: begin
            if (sts.can_insert) cmd.do_insert = 1'b1;
            else cmd.emit_fail = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SEARCH: begin
            if (sts.hit) begin
               cmd.emit_ans  = 1'b1;
               cmd.do_update = 1'b1;
               state_in = ST_IDLE;
            end else if (sts.search_done) begin
               cmd.emit_fail = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef NO_ASSERTIONS
   a_latch_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |-> state_ff == ST_IDLE) else $error("latch outside idle");
   a_one_end: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.do_insert, cmd.emit_fail, cmd.emit_ans}) <= 1)
      else $error("two answers at once");
   a_flip_pack: assert property (@(posedge clock) disable iff (reset)
      cmd.flip |=> state_ff == ST_PACK) else $error("flip without packing");
`endif

endmodule

/* rtl/rcop_datapath.sv */
// Object table, allocation counters and result register of the pool.
module rcop_datapath #(
   parameter int MAX_OBJECTS = rcop_pkg::MaxObjects,
   parameter int BANK_BYTES  = rcop_pkg::BankBytes,
   parameter int ID_BITS     = rcop_pkg::IdBits
) (
   input  logic              clock,
   input  logic              reset,
   input  rcop_pkg::req_type req,
   input  rcop_pkg::cmd_type cmd,
   output rcop_pkg::sts_type sts,
   output rcop_pkg::rsp_type rsp,
   output logic              rsp_strobe
);

   localparam int IdxW = $clog2(MAX_OBJECTS);
   localparam int CntW = $clog2(MAX_OBJECTS + 1);
   localparam int ByteW = $clog2(BANK_BYTES + 1);
   localparam logic [ID_BITS-1:0] IdMax = {ID_BITS{1'b1}};
   localparam logic [ByteW-1:0] BankB = ByteW'(BANK_BYTES);

   // Table entries: flip-flops, read at the walk index and at the found entry.
   logic [MAX_OBJECTS-1:0] valid_ff;
   logic [ID_BITS-1:0]     id_ff [MAX_OBJECTS];
   logic [15:0]            count_ff [MAX_OBJECTS];
   logic [ByteW-1:0]       off_ff [MAX_OBJECTS];
   logic [ByteW-1:0]       size_ff [MAX_OBJECTS];

   logic [CntW-1:0]    slots_ff;
   logic [ByteW-1:0]   bytes_ff;
   logic               bank_ff;
   logic [ID_BITS-1:0] last_id_ff;
   rcop_pkg::req_type  req_ff;

   // Walk pointers: i reads, j writes during packing; pos is the packed length.
   logic [CntW-1:0]  i_ff, j_ff;
   logic [ByteW-1:0] pos_ff;
   logic [IdxW-1:0]  ri, wj;

   rcop_pkg::rsp_type rsp_ff;
   logic              strobe_ff;

   logic [ByteW-1:0] sz;
   logic             size_fit, slot_free;

   assign ri = i_ff[IdxW-1:0];
   assign wj = j_ff[IdxW-1:0];
   assign sz = ByteW'(req_ff.request_bytes);
   assign size_fit  = sz <= BankB - bytes_ff;
   assign slot_free = slots_ff < CntW'(MAX_OBJECTS);

   // Status towards the controller.
   always_comb begin
      sts.bad_size     = (req_ff.request_bytes == '0) ||
                         (14'(req_ff.request_bytes) > 14'(BANK_BYTES));
      sts.need_compact = !size_fit || !slot_free;
      sts.can_insert   = size_fit && slot_free && (last_id_ff < IdMax);
      sts.search_done  = (i_ff == CntW'(MAX_OBJECTS));
      sts.hit          = !sts.search_done && (req_ff.handle != '0) && valid_ff[ri] &&
                         (id_ff[ri] == ID_BITS'(req_ff.handle));
      sts.move_done    = (i_ff >= slots_ff) || (i_ff == CntW'(MAX_OBJECTS));
   end

   // Control state of the table and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         slots_ff   <= '0;
         bytes_ff   <= '0;
         bank_ff    <= 1'b0;
         last_id_ff <= '0;
         strobe_ff  <= 1'b0;
         i_ff       <= '0;
         j_ff       <= '0;
         pos_ff     <= '0;
      end else begin
         strobe_ff <= 1'b0;
         if (cmd.search_clr) i_ff <= '0;
         if (cmd.search_step) i_ff <= i_ff + 1'b1;
         if (cmd.flip) begin
            bank_ff <= ~bank_ff;
            i_ff    <= '0;
            j_ff    <= '0;
            pos_ff  <= '0;
         end
         if (cmd.move_step) begin
            i_ff <= i_ff + 1'b1;
            if (valid_ff[ri]) begin
               valid_ff[ri] <= 1'b0;
               valid_ff[wj] <= 1'b1;
               j_ff         <= j_ff + 1'b1;
               pos_ff       <= pos_ff + size_ff[ri];
               strobe_ff    <= 1'b1;
            end
         end
         if (cmd.pack_end) begin
            slots_ff <= j_ff;
            bytes_ff <= pos_ff;
            for (int k = 0; k < MAX_OBJECTS; k++)
               if (CntW'(k) >= j_ff) valid_ff[k] <= 1'b0;
         end
         if (cmd.do_insert) begin
            valid_ff[slots_ff[IdxW-1:0]] <= 1'b1;
            slots_ff   <= slots_ff + 1'b1;
            bytes_ff   <= bytes_ff + sz;
            last_id_ff <= last_id_ff + 1'b1;
         end
         if (cmd.do_update && req_ff.op == rcop_pkg::OP_DROP &&
             count_ff[ri] <= 16'd1)
            valid_ff[ri] <= 1'b0;
         if (cmd.do_insert || cmd.emit_fail || cmd.emit_ans) strobe_ff <= 1'b1;
      end
   end

   // Payload: request capture, entry fields and the result register.
   always_ff @(posedge clock) begin
      if (cmd.latch) req_ff <= req;
      if (cmd.move_step && valid_ff[ri]) begin
         id_ff[wj]    <= id_ff[ri];
         count_ff[wj] <= count_ff[ri];
         size_ff[wj]  <= size_ff[ri];
         off_ff[wj]   <= pos_ff;
         rsp_ff <= '{kind: 1'b1, result_handle: 16'(id_ff[ri]), found: 1'b1,
                     bank: bank_ff, offset: 12'(pos_ff), old_offset: 12'(off_ff[ri]),
                     length: 13'(size_ff[ri]), last: 1'b0};
      end
      if (cmd.do_insert) begin
         id_ff[slots_ff[IdxW-1:0]]    <= last_id_ff + 1'b1;
         count_ff[slots_ff[IdxW-1:0]] <= 16'd1;
         off_ff[slots_ff[IdxW-1:0]]   <= bytes_ff;
         size_ff[slots_ff[IdxW-1:0]]  <= sz;
         rsp_ff <= '{kind: 1'b0, result_handle: 16'(last_id_ff + 1'b1), found: 1'b1,
                     bank: bank_ff, offset: 12'(bytes_ff), old_offset: 12'd0,
                     length: 13'(sz), last: 1'b1};
      end
      if (cmd.emit_fail)
         rsp_ff <= '{kind: 1'b0, result_handle: 16'd0, found: 1'b0, bank: bank_ff,
                     offset: 12'd0, old_offset: 12'd0, length: 13'd0, last: 1'b1};
      if (cmd.emit_ans)
         rsp_ff <= '{kind: 1'b0, result_handle: req_ff.handle, found: 1'b1,
                     bank: bank_ff, offset: 12'(off_ff[ri]), old_offset: 12'd0,
                     length: 13'(size_ff[ri]), last: 1'b1};
      if (cmd.do_update) begin
         if (req_ff.op == rcop_pkg::OP_ADD && count_ff[ri] != 16'hFFFF)
            count_ff[ri] <= count_ff[ri] + 16'd1;
         else if (req_ff.op == rcop_pkg::OP_DROP && count_ff[ri] != 16'd0)
            count_ff[ri] <= count_ff[ri] - 16'd1;
      end
   end

   assign rsp        = rsp_ff;
   assign rsp_strobe = strobe_ff;

`ifndef NO_ASSERTIONS
   a_slots_range: assert property (@(posedge clock) disable iff (reset)
      slots_ff <= CntW'(MAX_OBJECTS)) else $error("slot count beyond table");
   a_bytes_range: assert property (@(posedge clock) disable iff (reset)
      bytes_ff <= BankB) else $error("bank overfilled");
   a_pack_order: assert property (@(posedge clock) disable iff (reset)
      cmd.move_step |-> j_ff <= i_ff) else $error("pack write ahead of read");
`endif

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the reference-counted compacting object pool.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdMax    = (1 << rcop_pkg::IdBits) - 1;
   localparam int CountMax = 16'hFFFF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   rcop_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   rcop_pkg::rsp_type rsp_data;

   refcount_compacting_object_pool dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the pool state.
   logic        pool_valid[rcop_pkg::MaxObjects];
   logic [15:0] pool_id[rcop_pkg::MaxObjects];
   logic [15:0] pool_count[rcop_pkg::MaxObjects];
   logic [11:0] pool_offset[rcop_pkg::MaxObjects];
   logic [12:0] pool_size[rcop_pkg::MaxObjects];
   int          pool_slots;
   int          pool_bytes;
   logic        pool_bank;
   int          pool_last_id;

   rcop_pkg::rsp_type pending_rsp[$];
   int                failures = 0;
   int                issued_ids = 0;

   function automatic rcop_pkg::rsp_type make_rsp(logic kind, logic [15:0] h, logic fnd,
                                                  logic [11:0] off, logic [11:0] old,
                                                  logic [12:0] len, logic lst);
      rcop_pkg::rsp_type r;
      r.kind = kind; r.result_handle = h; r.found = fnd; r.bank = pool_bank;
      r.offset = off; r.old_offset = old; r.length = len; r.last = lst;
      return r;
   endfunction

   // Pack the live entries into the other bank, queueing one move each.
   task automatic compact_pool();
      int j;
      int pos;
      j = 0;
      pos = 0;
      pool_bank = ~pool_bank;
      for (int i = 0; i < pool_slots && i < rcop_pkg::MaxObjects; i++) begin
         if (pool_valid[i]) begin
            pending_rsp.push_back(make_rsp(1'b1, pool_id[i], 1'b1, pos[11:0],
                                           pool_offset[i], pool_size[i], 1'b0));
            pool_id[j] = pool_id[i];
            pool_count[j] = pool_count[i];
            pool_size[j] = pool_size[i];
            pool_offset[j] = pos[11:0];
            pool_valid[j] = 1'b1;
            pos += pool_size[i];
            j++;
         end
      end
      for (int i = j; i < rcop_pkg::MaxObjects; i++) pool_valid[i] = 1'b0;
      pool_slots = j;
      pool_bytes = pos;
   endtask

   // Work out the results of one accepted transaction.
   task automatic predict_pool(rcop_pkg::req_type rq);
      int e;
      int sz;
      e = -1;
      sz = rq.request_bytes;
      if (rq.op == rcop_pkg::OP_INSERT) begin
         if (sz == 0 || sz > rcop_pkg::BankBytes) begin
            pending_rsp.push_back(make_rsp(1'b0, '0, 1'b0, '0, '0, '0, 1'b1));
            return;
         end
         if (sz > rcop_pkg::BankBytes - pool_bytes || pool_slots >= rcop_pkg::MaxObjects)
            compact_pool();
         if (sz <= rcop_pkg::BankBytes - pool_bytes && pool_slots < rcop_pkg::MaxObjects &&
             pool_last_id < IdMax) begin
            pool_last_id++;
            pool_valid[pool_slots] = 1'b1;
            pool_id[pool_slots] = pool_last_id[15:0];
            pool_count[pool_slots] = 16'd1;
            pool_offset[pool_slots] = pool_bytes[11:0];
            pool_size[pool_slots] = sz[12:0];
            pending_rsp.push_back(make_rsp(1'b0, pool_last_id[15:0], 1'b1,
                                           pool_bytes[11:0], '0, sz[12:0], 1'b1));
            pool_slots++;
            pool_bytes += sz;
         end else begin
            pending_rsp.push_back(make_rsp(1'b0, '0, 1'b0, '0, '0, '0, 1'b1));
         end
         return;
      end
      if (rq.handle != 0)
         for (int i = rcop_pkg::MaxObjects - 1; i >= 0; i--)
            if (pool_valid[i] && pool_id[i] == rq.handle) e = i;
      if (e < 0) begin
         pending_rsp.push_back(make_rsp(1'b0, '0, 1'b0, '0, '0, '0, 1'b1));
         return;
      end
      pending_rsp.push_back(make_rsp(1'b0, rq.handle, 1'b1, pool_offset[e], '0,
                                     pool_size[e], 1'b1));
      if (rq.op == rcop_pkg::OP_ADD) begin
         if (pool_count[e] < CountMax) pool_count[e]++;
      end else if (rq.op == rcop_pkg::OP_DROP) begin
         if (pool_count[e] > 0) pool_count[e]--;
         if (pool_count[e] == 0) pool_valid[e] = 1'b0;
      end
   endtask

   // Compare each result transaction with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
            failures++;
         end else if (rsp_data !== pending_rsp[0]) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, pending_rsp[0],
                     rsp_data);
            failures++;
            void'(pending_rsp.pop_front());
         end else begin
            void'(pending_rsp.pop_front());
         end
      end
   end

   // Send one transaction, waiting for the pool to accept it. Start stays high
   // between back-to-back transactions and is dropped only over an idle gap.
   task automatic send_request(logic [1:0] op, int bytes, int h, logic gaps);
      rcop_pkg::req_type rq;
      rq.op = op;
      rq.request_bytes = bytes[12:0];
      rq.handle = h[15:0];
      if (gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_pool(rq);
      if (op == rcop_pkg::OP_INSERT && pending_rsp[$].found) issued_ids++;
   endtask

   // Directed rows; the check column holds an answer readable by eye.
   typedef struct {
      logic [1:0]        op;
      int                bytes;
      int                h;
      logic              fixed;
      rcop_pkg::rsp_type want;
   } row_type;

   function automatic rcop_pkg::rsp_type fail_rsp(logic bk);
      rcop_pkg::rsp_type r;
      r = '0;
      r.bank = bk;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic int live_handle();
      int n;
      int pick;
      n = 0;
      for (int i = 0; i < rcop_pkg::MaxObjects; i++) if (pool_valid[i]) n++;
      if (n == 0) return $urandom_range(0, 40);
      pick = $urandom_range(0, n - 1);
      for (int i = 0; i < rcop_pkg::MaxObjects; i++)
         if (pool_valid[i]) begin
            if (pick == 0) return pool_id[i];
            pick--;
         end
      return 0;
   endfunction

   initial begin
      row_type           rows[$];
      row_type           r;
      int                op;
      int                bytes;
      int                h;
      rcop_pkg::rsp_type want;

      for (int i = 0; i < rcop_pkg::MaxObjects; i++) pool_valid[i] = 1'b0;
      pool_slots = 0; pool_bytes = 0; pool_bank = 1'b0; pool_last_id = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: errors, extremes, exact fit and saturation paths.
      want = make_rsp(1'b0, 16'd1, 1'b1, '0, '0, 13'd1, 1'b1);
      rows.push_back('{rcop_pkg::OP_RETRIEVE, 0, 0, 1'b1, fail_rsp(1'b0)});
      rows.push_back('{rcop_pkg::OP_INSERT, 0, 0, 1'b1, fail_rsp(1'b0)});
      rows.push_back('{rcop_pkg::OP_INSERT, 4097, 0, 1'b1, fail_rsp(1'b0)});
      rows.push_back('{rcop_pkg::OP_INSERT, 8191, 65535, 1'b1, fail_rsp(1'b0)});
      rows.push_back('{rcop_pkg::OP_INSERT, 1, 0, 1'b1, want});
      rows.push_back('{rcop_pkg::OP_RETRIEVE, 0, 65535, 1'b1, fail_rsp(1'b0)});
      rows.push_back('{rcop_pkg::OP_INSERT, 4095, 0, 1'b0, want});
      rows.push_back('{rcop_pkg::OP_ADD, 0, 1, 1'b0, want});
      rows.push_back('{rcop_pkg::OP_DROP, 0, 2, 1'b0, want});
      rows.push_back('{rcop_pkg::OP_INSERT, 4096, 0, 1'b0, want});
      rows.push_back('{rcop_pkg::OP_RETRIEVE, 8191, 1, 1'b0, want});
      rows.push_back('{rcop_pkg::OP_DROP, 0, 1, 1'b0, want});
      rows.push_back('{rcop_pkg::OP_DROP, 0, 1, 1'b0, want});
      rows.push_back('{rcop_pkg::OP_DROP, 0, 3, 1'b0, want});
      rows.push_back('{rcop_pkg::OP_ADD, 0, 3, 1'b1, fail_rsp(1'b1)});
      rows.push_back('{rcop_pkg::OP_INSERT, 4096, 0, 1'b0, want});
      for (int i = 0; i < 34; i++) rows.push_back('{rcop_pkg::OP_INSERT, 2, 0, 1'b0, want});
      foreach (rows[i]) begin
         r = rows[i];
         send_request(r.op, r.bytes, r.h, 1'b0);
         if (r.fixed && pending_rsp[$] !== r.want) begin
            $display("%0t: directed row %0d, expected %p, actual prediction %p",
                     $time, i, r.want, pending_rsp[$]);
            failures++;
         end
      end

      // Random part: mostly live handles and small sizes, with gaps early on.
      for (int n = 0; n < 130; n++) begin
         op = $urandom_range(0, 3);
         bytes = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 8191)
                                              : $urandom_range(1, 300);
         h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : live_handle();
         send_request(op[1:0], bytes, h, n < 100);
      end

      // Drive one handle towards count saturation with a burst of adds.
      h = live_handle();
      for (int n = 0; n < 20; n++) send_request(rcop_pkg::OP_ADD, 1, h, 1'b0);
      start <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (rcop_pkg::MaxObjects + 10) @(posedge clock);
      if (failures == 0) $display("refcount_compacting_object_pool verification clean");
      else $display("refcount_compacting_object_pool verification failed");
      $finish;
   end

   // Overall limit on the run.
   initial begin
      #5ms;
      $display("refcount_compacting_object_pool verification failed");
      $finish;
   end

endmodule

/* refcount_compacting_object_pool.f */
rtl/rcop_pkg.sv
rtl/rcop_ctrl.sv
rtl/rcop_datapath.sv
rtl/refcount_compacting_object_pool.sv
tb/testbench.sv
